// ===== design/tscd_pkg.sv =====
// ---------------------------------------------------------------------------
// tscd_pkg
// Shared types and constants for the tiered segment cost block.
// ---------------------------------------------------------------------------
package tscd_pkg;

	localparam int MAX_STATIONS = 256;
	localparam int SLOT_W       = $clog2(MAX_STATIONS);
	localparam int CNT_W        = $clog2(MAX_STATIONS + 1);
	localparam int POS_W        = 32;
	localparam int FARE_W       = 32;
	localparam int COST_W       = 48;
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = 32;

	localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_TIER1_LIMIT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TIER2_LIMIT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TIER3_LIMIT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_TIER1_FARE  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_TIER2_FARE  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_TIER3_FARE  = 3'd5;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_DRAIN,
		ST_FINISH
	} tscd_state_t;

	// controller -> datapath
	typedef struct packed {
		logic load;    // take the input item
		logic issue;   // read the next earlier station
		logic commit;  // store the station, emit result if last
	} tscd_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic restart;   // incoming item starts a new trip
		logic at_end;    // current read is the oldest stored station
		logic brk;       // walk has run out of reach
		logic busy;      // reads still in the evaluation pipe
		logic out_block; // last station, result register full and not being taken
	} tscd_status_t;

endpackage

// ===== design/tscd_ctrl.sv =====
// ---------------------------------------------------------------------------
// tscd_ctrl
// Sequencer: accept, walk back over stored stations, drain, commit.
// ---------------------------------------------------------------------------
module tscd_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  tscd_pkg::tscd_status_t status,
	output tscd_pkg::tscd_cmd_t    cmd
);

	tscd_pkg::tscd_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tscd_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		in_ready   = 1'b0;
		cmd        = '0;
		unique case (state_q)
			tscd_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = status.restart ? tscd_pkg::ST_FINISH : tscd_pkg::ST_WALK;
				end
			end
			tscd_pkg::ST_WALK: begin
				if (status.brk) begin
					state_d = tscd_pkg::ST_DRAIN;
				end else begin
					cmd.issue = 1'b1;
					if (status.at_end) begin
						state_d = tscd_pkg::ST_DRAIN;
					end
				end
			end
			tscd_pkg::ST_DRAIN: begin
				if (!status.busy) begin
					state_d = tscd_pkg::ST_FINISH;
				end
			end
			tscd_pkg::ST_FINISH: begin
				if (!status.out_block) begin
					cmd.commit = 1'b1;
					state_d    = tscd_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = tscd_pkg::ST_IDLE;
			end
		endcase
	end

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q != tscd_pkg::ST_IDLE))
		else $error("accepted item did not start work");

endmodule

// ===== design/tscd_dp.sv =====
// ---------------------------------------------------------------------------
// tscd_dp
// Datapath: tier registers, station store, two-stage evaluation pipe,
// running minimum and result register.
// ---------------------------------------------------------------------------
module tscd_dp (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    cfg_wr_en,
	input  logic [tscd_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  logic [tscd_pkg::CFG_DATA_W-1:0]         cfg_wr_data,
	input  logic [tscd_pkg::POS_W-1:0]              station_position,
	input  logic                                    first_station,
	input  logic                                    last_station,
	output logic                                    out_valid,
	input  logic                                    out_ready,
	output logic [tscd_pkg::COST_W-1:0]             total_fare,
	input  tscd_pkg::tscd_cmd_t                     cmd,
	output tscd_pkg::tscd_status_t                  status
);

	// tier registers
	logic [tscd_pkg::POS_W-1:0]  lim1_q, lim2_q, lim3_q;
	logic [tscd_pkg::FARE_W-1:0] fare1_q, fare2_q, fare3_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim1_q  <= '0;
			lim2_q  <= '0;
			lim3_q  <= '0;
			fare1_q <= '0;
			fare2_q <= '0;
			fare3_q <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				tscd_pkg::CFG_TIER1_LIMIT: lim1_q  <= cfg_wr_data;
				tscd_pkg::CFG_TIER2_LIMIT: lim2_q  <= cfg_wr_data;
				tscd_pkg::CFG_TIER3_LIMIT: lim3_q  <= cfg_wr_data;
				tscd_pkg::CFG_TIER1_FARE:  fare1_q <= cfg_wr_data;
				tscd_pkg::CFG_TIER2_FARE:  fare2_q <= cfg_wr_data;
				tscd_pkg::CFG_TIER3_FARE:  fare3_q <= cfg_wr_data;
				default: ;
			endcase
		end
	end

	// current item
	logic [tscd_pkg::POS_W-1:0] pos_q;
	logic                       last_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			pos_q  <= station_position;
			last_q <= last_station;
		end
	end

	// store bookkeeping
	logic [tscd_pkg::SLOT_W-1:0] wslot_q;
	logic [tscd_pkg::CNT_W-1:0]  count_q;
	logic [tscd_pkg::CNT_W-1:0]  step_q;
	logic                        restart;

	assign restart = first_station || (count_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wslot_q <= '0;
			count_q <= '0;
			step_q  <= '0;
		end else begin
			if (cmd.load) begin
				step_q <= tscd_pkg::CNT_W'(1);
				if (restart) begin
					wslot_q <= '0;
					count_q <= '0;
				end
			end else if (cmd.issue) begin
				step_q <= step_q + 1'b1;
			end
			if (cmd.commit) begin
				wslot_q <= (wslot_q == tscd_pkg::SLOT_W'(tscd_pkg::MAX_STATIONS - 1)) ?
					'0 : wslot_q + 1'b1;
				if (count_q != tscd_pkg::CNT_W'(tscd_pkg::MAX_STATIONS)) begin
					count_q <= count_q + 1'b1;
				end
			end
		end
	end

	// read slot: step places behind the write slot, circular
	logic [tscd_pkg::CNT_W-1:0]  wslot_ext;
	logic [tscd_pkg::SLOT_W-1:0] rd_addr;

	assign wslot_ext = tscd_pkg::CNT_W'(wslot_q);
	always_comb begin
		if (wslot_ext >= step_q) begin
			rd_addr = tscd_pkg::SLOT_W'(wslot_ext - step_q);
		end else begin
			rd_addr = tscd_pkg::SLOT_W'(wslot_ext + tscd_pkg::CNT_W'(tscd_pkg::MAX_STATIONS)
				- step_q);
		end
	end

	// station store
	logic [tscd_pkg::POS_W-1:0]  pos_mem  [tscd_pkg::MAX_STATIONS];
	logic [tscd_pkg::COST_W-1:0] cost_mem [tscd_pkg::MAX_STATIONS];
	logic [tscd_pkg::COST_W-1:0] cost_q;

	logic [tscd_pkg::POS_W-1:0]  pos_rd_s1;
	logic [tscd_pkg::COST_W-1:0] cost_rd_s1;

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			pos_mem[wslot_q]  <= pos_q;
			cost_mem[wslot_q] <= cost_q;
		end
		if (cmd.issue) begin
			pos_rd_s1  <= pos_mem[rd_addr];
			cost_rd_s1 <= cost_mem[rd_addr];
		end
	end

	// stage 1: distance and tier choice
	logic v_s1, nearest_s1, halt_q;
	logic [tscd_pkg::POS_W-1:0]  gap;
	logic                        in_reach, brk_now;
	logic [tscd_pkg::FARE_W-1:0] tier_fare, fare_pick;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1       <= 1'b0;
			nearest_s1 <= 1'b0;
		end else begin
			v_s1       <= cmd.issue;
			nearest_s1 <= (step_q == tscd_pkg::CNT_W'(1));
		end
	end

	// out of reach when the stored station lies ahead or the gap passes every tier limit
	assign gap      = pos_q - pos_rd_s1;
	assign in_reach = (pos_rd_s1 <= pos_q) &&
		((gap <= lim1_q) || (gap <= lim2_q) || (gap <= lim3_q));
	assign brk_now  = v_s1 && !halt_q && !in_reach;

	always_comb begin
		if (gap <= lim1_q) begin
			tier_fare = fare1_q;
		end else if (gap <= lim2_q) begin
			tier_fare = fare2_q;
		end else begin
			tier_fare = fare3_q;
		end
		// nearest station also carries the fallback hop at fare3
		if (nearest_s1) begin
			fare_pick = (in_reach && (tier_fare < fare3_q)) ? tier_fare : fare3_q;
		end else begin
			fare_pick = tier_fare;
		end
	end

	// stage 2: saturating add and running minimum
	logic                        v_s2;
	logic [tscd_pkg::FARE_W-1:0] fare_s2;
	logic [tscd_pkg::COST_W-1:0] cost_s2;
	logic [tscd_pkg::COST_W:0]   sum;
	logic [tscd_pkg::COST_W-1:0] cand;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2   <= 1'b0;
			halt_q <= 1'b0;
		end else begin
			v_s2 <= v_s1 && !halt_q && (in_reach || nearest_s1);
			if (cmd.load) begin
				halt_q <= 1'b0;
			end else if (brk_now) begin
				halt_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		fare_s2 <= fare_pick;
		cost_s2 <= cost_rd_s1;
	end

	assign sum  = {1'b0, cost_s2} + (tscd_pkg::COST_W + 1)'(fare_s2);
	assign cand = sum[tscd_pkg::COST_W] ? tscd_pkg::COST_MAX : sum[tscd_pkg::COST_W-1:0];

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cost_q <= restart ? '0 : tscd_pkg::COST_MAX;
		end else if (v_s2 && (cand < cost_q)) begin
			cost_q <= cand;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.commit && last_q) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit && last_q) begin
			total_fare <= cost_q;
		end
	end

	assign status.restart   = restart;
	assign status.at_end    = (step_q == count_q);
	assign status.brk       = halt_q || brk_now;
	assign status.busy      = v_s1 || v_s2;
	assign status.out_block = last_q && out_valid && !out_ready;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= tscd_pkg::CNT_W'(tscd_pkg::MAX_STATIONS))
		else $error("station count past store depth");

	a_commit_drained: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> !(v_s1 || v_s2))
		else $error("commit while reads still in flight");

	a_result_shown: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && last_q) |=> out_valid)
		else $error("last station committed without a result");

endmodule

// ===== design/tiered_segment_cost_dp.sv =====
// ---------------------------------------------------------------------------
// tiered_segment_cost_dp
// Least total tiered fare along a run of stations on a line.
// ---------------------------------------------------------------------------
//
//   channel  signals                                        direction
//   -------  ---------------------------------------------  ---------
//   input    in_valid/in_ready, station_position,
//            first_station, last_station                   in
//   output   out_valid/out_ready, total_fare               out
//   config   cfg_wr_en, cfg_index, cfg_wr_data             in
//
// An item that starts a trip (or arrives with an empty store) goes from accept
// straight to commit. Any other item walks back over the earlier stations,
// one store read per cycle, stopping at the first out-of-reach station and
// at most at the stored count (up to MAX_STATIONS), then drains the
// evaluation pipe before it commits.
// Reset clears the tier registers, store count and write slot; the store
// contents are not cleared and need no clearing pass.
// A full result register stalls only the commit of a trip's last station.
//
module tiered_segment_cost_dp (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration
	input  logic                            cfg_wr_en,
	input  logic [tscd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tscd_pkg::CFG_DATA_W-1:0] cfg_wr_data,
	// input items
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [tscd_pkg::POS_W-1:0]      station_position,
	input  logic                            first_station,
	input  logic                            last_station,
	// result items
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [tscd_pkg::COST_W-1:0]     total_fare
);

	tscd_pkg::tscd_cmd_t    cmd;
	tscd_pkg::tscd_status_t status;

	// sequencer: accept, walk, drain, commit
	tscd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	// store, evaluation pipe and result register
	tscd_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_wr_en        (cfg_wr_en),
		.cfg_index        (cfg_index),
		.cfg_wr_data      (cfg_wr_data),
		.station_position (station_position),
		.first_station    (first_station),
		.last_station     (last_station),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.total_fare       (total_fare),
		.cmd              (cmd),
		.status           (status)
	);

endmodule
